// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle and next-cycle implication checks, clocked on the rising edge
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// ----- hdl/btmx_pkg.sv -----
`default_nettype none

package btmx_pkg;

    localparam int BITS_DEF  = 31;
    localparam int NODES_DEF = 65536;
    localparam int VALUE_W   = 31;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic short_done;
        logic walk_end;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- hdl/binary_trie_max_xor.sv -----
// Maximum-XOR binary trie. An insert word (op 0) stores value in a trie held in
// a node pool of NODES rows, one read and at most one write of the pool per trie
// level; a query word (op 1) walks the trie toward the opposite bit and returns
// the largest XOR of value with any stored value. Every word gives one result.
// A word is taken in idle and walks the trie level by level, one pool read per
// level, before its result is loaded; a refused insert (fewer than BITS free
// nodes) or a query on an empty trie skips the walk. The result sits in an output
// register, so a new word is taken while the last result waits. Nodes are
// allocated in order and a row is first written when its node gains a child,
// so the pool needs no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module binary_trie_max_xor #(
    parameter int BITS  = btmx_pkg::BITS_DEF,
    parameter int NODES = btmx_pkg::NODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic [btmx_pkg::VALUE_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [btmx_pkg::VALUE_W-1:0]       xor_result,
    output logic                               overflow,
    output logic                               empty_res
);

    btmx_pkg::cmd_t  cmd;
    btmx_pkg::stat_t stat;

    btmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    btmx_dp #(
        .BITS  (BITS),
        .NODES (NODES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .xor_result (xor_result),
        .overflow   (overflow),
        .empty_res  (empty_res)
    );

    `ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid, !(overflow && empty_res))
    `ASSERT_IMPL(a_refused_zero, clk, rst_n, out_valid && (overflow || empty_res), xor_result == '0)
    `ASSERT_NEXT(a_busy_after_load, clk, rst_n, cmd.load, in_stall)
    `ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.step, cmd.out_load}))

endmodule

`default_nettype wire

// ----- hdl/btmx_dp.sv -----
`default_nettype none

module btmx_dp #(
    parameter int BITS  = btmx_pkg::BITS_DEF,
    parameter int NODES = btmx_pkg::NODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire btmx_pkg::cmd_t                cmd,
    output btmx_pkg::stat_t                    stat,
    input  wire logic                          op,
    input  wire logic [btmx_pkg::VALUE_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [btmx_pkg::VALUE_W-1:0]       xor_result,
    output logic                               overflow,
    output logic                               empty_res
);

    localparam int PW    = $clog2(NODES);
    localparam int LW    = $clog2(BITS);
    localparam int VW    = btmx_pkg::VALUE_W;
    localparam int LIMIT = NODES - 1 - BITS;

    // node pool: one row per node, {child for bit 1, child for bit 0}
    logic [2*PW-1:0] mem [NODES];
    logic [2*PW-1:0] rdata_reg;

    logic          op_reg;
    logic [VW-1:0] value_reg;
    logic [PW-1:0] node_reg;
    logic [LW-1:0] lvl_reg;
    logic          fresh_reg;
    logic [PW-1:0] used_reg;
    logic [PW-1:0] used_next;
    logic [VW-1:0] res_reg;
    logic [VW-1:0] res_next;
    logic          ovf_reg;
    logic          emp_reg;
    logic          out_valid_reg;
    logic [VW-1:0] out_res_reg;
    logic          out_ovf_reg;
    logic          out_emp_reg;

    logic            pool_full;
    logic            trie_empty;
    logic            val_bit;
    logic [2*PW-1:0] row;
    logic [PW-1:0]   c0;
    logic [PW-1:0]   c1;
    logic [PW-1:0]   same;
    logic [PW-1:0]   opp;
    logic [PW-1:0]   alloc;
    logic [PW-1:0]   next_node;
    logic [PW-1:0]   raddr;
    logic [2*PW-1:0] wrow;
    logic            we;
    logic            take_opp;
    logic            dead;

    assign pool_full  = (LIMIT < 0) ? 1'b1 : (used_reg > PW'(LIMIT));
    assign trie_empty = (used_reg == '0);

    always_comb
    begin
        val_bit = 1'b0;
        for (int i = 0; i < VW; i++)
        begin
            if (int'(lvl_reg) == i)
            begin
                val_bit = value_reg[i];
            end
        end
    end

    // rows of nodes allocated in this walk were never written: read them as empty
    assign row   = fresh_reg ? '0 : rdata_reg;
    assign c0    = row[PW-1:0];
    assign c1    = row[2*PW-1:PW];
    assign same  = val_bit ? c1 : c0;
    assign opp   = val_bit ? c0 : c1;
    assign alloc = used_reg + PW'(1);

    always_comb
    begin
        next_node = node_reg;
        we        = 1'b0;
        wrow      = row;
        take_opp  = 1'b0;
        dead      = 1'b0;
        if (op_reg == btmx_pkg::OP_INSERT)
        begin
            if (same != '0)
            begin
                next_node = same;
            end
            else
            begin
                we        = 1'b1;
                next_node = alloc;
                if (val_bit)
                begin
                    wrow[2*PW-1:PW] = alloc;
                end
                else
                begin
                    wrow[PW-1:0] = alloc;
                end
            end
        end
        else
        begin
            if (opp != '0)
            begin
                take_opp  = 1'b1;
                next_node = opp;
            end
            else if (same != '0)
            begin
                next_node = same;
            end
            else
            begin
                dead = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < VW; i++)
        begin
            res_next[i] = res_reg[i] | (take_opp && (int'(lvl_reg) == i));
        end
    end

    assign used_next = (cmd.step && we) ? alloc : used_reg;
    assign raddr     = cmd.load ? '0 : next_node;

    always_ff @(posedge clk)
    begin
        if (cmd.step && we)
        begin
            mem[node_reg] <= wrow;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            value_reg <= value;
            node_reg  <= '0;
            lvl_reg   <= LW'(BITS - 1);
            fresh_reg <= (op == btmx_pkg::OP_INSERT) && trie_empty;
            res_reg   <= '0;
            ovf_reg   <= (op == btmx_pkg::OP_INSERT) && pool_full;
            emp_reg   <= (op == btmx_pkg::OP_QUERY) && trie_empty;
        end
        else if (cmd.step)
        begin
            node_reg <= next_node;
            lvl_reg  <= lvl_reg - LW'(1);
            res_reg  <= res_next;
            if (we)
            begin
                fresh_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_res_reg <= res_reg;
            out_ovf_reg <= ovf_reg;
            out_emp_reg <= emp_reg;
        end
    end

    assign stat.short_done = (op == btmx_pkg::OP_QUERY) ? trie_empty : pool_full;
    assign stat.walk_end   = (lvl_reg == '0) || dead;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign xor_result = out_res_reg;
    assign overflow   = out_ovf_reg;
    assign empty_res  = out_emp_reg;

endmodule

`default_nettype wire

// ----- hdl/btmx_ctrl.sv -----
`default_nettype none

module btmx_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output btmx_pkg::cmd_t       cmd,
    input  wire btmx_pkg::stat_t stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.short_done ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign cmd.load     = in_valid && (state_reg == ST_IDLE);
    assign cmd.step     = (state_reg == ST_WALK);
    assign cmd.out_load = (state_reg == ST_FINISH) && stat.out_free;

endmodule

`default_nettype wire
